// File: hdl/gbni_pkg.sv
// Package for the bilinear grid interpolator: sizes, fixed-point constants,
// register indexes. Used by the interfaces, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package gbni_pkg;

    localparam int GRID_COLS = 256;
    localparam int GRID_ROWS = 256;
    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int BANK_AW = (COL_W - 1) + (ROW_W - 1);
    localparam int BANK_DEPTH = 2 ** BANK_AW;

    localparam int CFG_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam int HEIGHT_W = 32;
    localparam int DEG_W = 38;
    localparam int PP_W = 45;
    localparam int PROD_W = 86;
    localparam int SUM_W = 88;
    localparam int INT_LSB = 55;
    localparam int FRAC_LSB = 39;
    localparam int FRAC_W = 16;
    localparam int WGT_W = 33;
    localparam int HW_W = 65;
    localparam int ACC_W = 67;
    localparam int REM_W = 66;
    localparam int QUO_W = 32;

    localparam logic [29:0] DEG_PER_RAD = 30'd961263669;
    localparam logic [WGT_W-1:0] EPS_WGT = 33'd42950;
    localparam logic [FRAC_W:0] ONE_Q16 = 17'd65536;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL_OFFSET = 3'd0,
        CFG_COL_PER_X  = 3'd1,
        CFG_COL_PER_Y  = 3'd2,
        CFG_ROW_OFFSET = 3'd3,
        CFG_ROW_PER_X  = 3'd4,
        CFG_ROW_PER_Y  = 3'd5,
        CFG_NODATA     = 3'd6
    } t_cfg_idx;

endpackage

// File: hdl/gbni_if.sv
// Channel interfaces of the bilinear grid interpolator: input items, results
// and configuration writes. Depends on gbni_pkg.
`timescale 1ns / 1ps

interface gbni_in_if;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [7:0]               cell_col;
    logic [7:0]               cell_row;
    logic signed [31:0]       cell_height;
    logic signed [31:0]       query_x;
    logic signed [31:0]       query_y;

    modport source (output valid, action, cell_col, cell_row, cell_height, query_x, query_y,
                    input ready);
    modport sink (input valid, action, cell_col, cell_row, cell_height, query_x, query_y,
                  output ready);
endinterface

interface gbni_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       height_out;
    logic                     in_range;
    logic                     no_valid_data;

    modport source (output valid, height_out, in_range, no_valid_data, input ready);
    modport sink (input valid, height_out, in_range, no_valid_data, output ready);
endinterface

interface gbni_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [gbni_pkg::CFG_IDX_W-1:0]   index;
    logic [gbni_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/grid_bilinear_nodata_interp.sv
// Top level of the bilinear grid interpolator with nodata masking.
// Depends on gbni_pkg, the interfaces in gbni_if and gbni_ram.
//
// Write transactions store one Q16.16 height in a 256x256 grid held in four
// row/column-parity RAM banks, so the whole 2x2 neighbourhood of a query is read
// at once. Query transactions give one result each: angle to degrees, affine
// map, floor, bilinear blend without nodata cells, then a restoring divider that
// yields one quotient bit per stage. One transaction is accepted every cycle while
// the pipeline is not stalled; the 32-stage divider feeds a registered output.
// Writes take effect for every query accepted after them. The pipeline stalls as
// a whole only while a result waits at the output. The grid has no reset value.
`timescale 1ns / 1ps

module grid_bilinear_nodata_interp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gbni_in_if.sink        i_in,
    gbni_out_if.source     o_out,
    gbni_cfg_if.sink       i_cfg
);

    localparam int NDIV = gbni_pkg::QUO_W;

    logic en;

    // configuration
    logic signed [gbni_pkg::CFG_W-1:0]    r_cfg [6];
    logic signed [gbni_pkg::HEIGHT_W-1:0] r_nodata;

    // stage 1..4
    logic r1_v, r2_v, r3_v, r4_v;
    logic r1_act, r2_act, r3_act, r4_act;
    logic [7:0] r1_col, r2_col, r3_col, r4_col;
    logic [7:0] r1_row, r2_row, r3_row, r4_row;
    logic signed [gbni_pkg::HEIGHT_W-1:0] r1_h, r2_h, r3_h, r4_h;
    logic signed [gbni_pkg::DEG_W-1:0] r1_deg [2];
    logic signed [gbni_pkg::DEG_W-1:0] n_deg [2];
    logic signed [61:0] n_rawdeg [2];
    logic signed [gbni_pkg::PP_W-1:0] r2_pp [4][4];
    logic signed [gbni_pkg::PP_W-1:0] n_pp [4][4];
    logic signed [gbni_pkg::PROD_W-1:0] r3_prod [4];
    logic signed [gbni_pkg::PROD_W-1:0] n_prod [4];
    logic signed [gbni_pkg::SUM_W-1:0] r4_sum [2];
    logic signed [gbni_pkg::SUM_W-1:0] n_sum [2];

    // RAM access
    logic [gbni_pkg::COL_W-1:0] px;
    logic [gbni_pkg::ROW_W-1:0] py;
    logic signed [32:0] ipx, ipy;
    logic n_inr;
    logic [gbni_pkg::COL_W-1:0] wcol;
    logic [gbni_pkg::ROW_W-1:0] wrow;
    logic wr_ok;
    logic [gbni_pkg::BANK_AW-1:0] raddr [4];
    logic [gbni_pkg::HEIGHT_W-1:0] rdata [4];
    logic [3:0] bank_we;

    // stage 5..8
    logic r5_v, r6_v, r7_v, r8_v;
    logic r5_inr, r6_inr, r7_inr, r8_inr;
    logic [gbni_pkg::FRAC_W-1:0] r5_dx, r5_dy;
    logic r5_px0, r5_py0;
    logic signed [gbni_pkg::HEIGHT_W-1:0] r6_hgt [4];
    logic signed [gbni_pkg::HEIGHT_W-1:0] n_hgt [4];
    logic [gbni_pkg::WGT_W-1:0] r6_w [4];
    logic [gbni_pkg::WGT_W-1:0] n_w [4];
    logic [3:0] r6_use;
    logic [3:0] n_use;
    logic [gbni_pkg::FRAC_W:0] wx0, wx1, wy0, wy1;
    logic signed [gbni_pkg::HW_W-1:0] r7_hw [4];
    logic signed [gbni_pkg::HW_W-1:0] n_hw [4];
    logic [gbni_pkg::WGT_W-1:0] r7_norm, r8_norm;
    logic [gbni_pkg::WGT_W-1:0] n_norm;
    logic signed [gbni_pkg::ACC_W-1:0] r8_acc;
    logic r8_nov;
    logic signed [gbni_pkg::ACC_W-1:0] mag;
    logic [gbni_pkg::REM_W-1:0] n_dividend;

    // divider
    logic r_dv [NDIV+1];
    logic r_dinr [NDIV+1];
    logic r_dnov [NDIV+1];
    logic r_dneg [NDIV+1];
    logic [gbni_pkg::REM_W-1:0] r_drem [NDIV+1];
    logic [gbni_pkg::WGT_W-1:0] r_dden [NDIV+1];
    logic [gbni_pkg::QUO_W-1:0] r_dq [NDIV+1];

    // output
    logic r_ov, r_oinr, r_onov;
    logic signed [gbni_pkg::HEIGHT_W-1:0] r_oh;
    logic [gbni_pkg::QUO_W-1:0] qs;

    assign en = !r_ov || o_out.ready;
    assign i_in.ready = en && i_rst_n;
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_cfg[k] <= '0;
            end
            r_nodata <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                gbni_pkg::CFG_COL_OFFSET: r_cfg[0] <= i_cfg.data;
                gbni_pkg::CFG_COL_PER_X:  r_cfg[1] <= i_cfg.data;
                gbni_pkg::CFG_COL_PER_Y:  r_cfg[2] <= i_cfg.data;
                gbni_pkg::CFG_ROW_OFFSET: r_cfg[3] <= i_cfg.data;
                gbni_pkg::CFG_ROW_PER_X:  r_cfg[4] <= i_cfg.data;
                gbni_pkg::CFG_ROW_PER_Y:  r_cfg[5] <= i_cfg.data;
                gbni_pkg::CFG_NODATA:     r_nodata <= i_cfg.data[gbni_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // radians to degrees, floor
    always_comb begin
        n_rawdeg[0] = 62'(i_in.query_x) * $signed({1'b0, gbni_pkg::DEG_PER_RAD});
        n_rawdeg[1] = 62'(i_in.query_y) * $signed({1'b0, gbni_pkg::DEG_PER_RAD});
        for (int k = 0; k < 2; k++) begin
            n_deg[k] = n_rawdeg[k][61:24];
        end
    end

    // partial products: coefficient split 24/24, degrees split 19/19
    always_comb begin
        logic signed [24:0] c_lo, c_hi;
        logic signed [19:0] d_lo, d_hi;
        logic signed [gbni_pkg::CFG_W-1:0] c;
        logic signed [gbni_pkg::DEG_W-1:0] d;
        for (int k = 0; k < 4; k++) begin
            c = r_cfg[(k < 2) ? (k + 1) : (k + 2)];
            d = r1_deg[k % 2];
            c_lo = $signed({1'b0, c[23:0]});
            c_hi = 25'($signed(c[47:24]));
            d_lo = $signed({1'b0, d[18:0]});
            d_hi = 20'($signed(d[37:19]));
            n_pp[k][0] = gbni_pkg::PP_W'(c_lo * d_lo);
            n_pp[k][1] = gbni_pkg::PP_W'(c_hi * d_lo);
            n_pp[k][2] = gbni_pkg::PP_W'(c_lo * d_hi);
            n_pp[k][3] = gbni_pkg::PP_W'(c_hi * d_hi);
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_prod[k] = gbni_pkg::PROD_W'(r2_pp[k][0])
                      + (gbni_pkg::PROD_W'(r2_pp[k][1]) <<< 24)
                      + (gbni_pkg::PROD_W'(r2_pp[k][2]) <<< 19)
                      + (gbni_pkg::PROD_W'(r2_pp[k][3]) <<< 43);
        end
        n_sum[0] = (gbni_pkg::SUM_W'(r_cfg[0]) <<< 28)
                 + gbni_pkg::SUM_W'(r3_prod[0]) + gbni_pkg::SUM_W'(r3_prod[1]);
        n_sum[1] = (gbni_pkg::SUM_W'(r_cfg[3]) <<< 28)
                 + gbni_pkg::SUM_W'(r3_prod[2]) + gbni_pkg::SUM_W'(r3_prod[3]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_act <= i_in.action;
            r1_col <= i_in.cell_col;
            r1_row <= i_in.cell_row;
            r1_h   <= i_in.cell_height;
            r1_deg <= n_deg;
            r2_act <= r1_act;
            r2_col <= r1_col;
            r2_row <= r1_row;
            r2_h   <= r1_h;
            r2_pp  <= n_pp;
            r3_act <= r2_act;
            r3_col <= r2_col;
            r3_row <= r2_row;
            r3_h   <= r2_h;
            r3_prod <= n_prod;
            r4_act <= r3_act;
            r4_col <= r3_col;
            r4_row <= r3_row;
            r4_h   <= r3_h;
            r4_sum <= n_sum;
        end
    end

    // neighbourhood addressing and grid writes
    always_comb begin
        logic [gbni_pkg::COL_W-1:0] cs;
        logic [gbni_pkg::ROW_W-1:0] rs;
        ipx = r4_sum[0][gbni_pkg::SUM_W-1:gbni_pkg::INT_LSB];
        ipy = r4_sum[1][gbni_pkg::SUM_W-1:gbni_pkg::INT_LSB];
        px = ipx[gbni_pkg::COL_W-1:0];
        py = ipy[gbni_pkg::ROW_W-1:0];
        n_inr = !ipx[32] && !ipy[32]
             && (ipx[31:0] <= 32'(gbni_pkg::GRID_COLS - 2))
             && (ipy[31:0] <= 32'(gbni_pkg::GRID_ROWS - 2));
        for (int b = 0; b < 4; b++) begin
            cs = px + gbni_pkg::COL_W'(px[0] != b[0]);
            rs = py + gbni_pkg::ROW_W'(py[0] != b[1]);
            raddr[b] = {rs[gbni_pkg::ROW_W-1:1], cs[gbni_pkg::COL_W-1:1]};
        end
        wcol = gbni_pkg::COL_W'(r4_col);
        wrow = gbni_pkg::ROW_W'(r4_row);
        wr_ok = en && r4_v && (r4_act == gbni_pkg::ACT_WRITE)
             && (32'(r4_col) < 32'(gbni_pkg::GRID_COLS))
             && (32'(r4_row) < 32'(gbni_pkg::GRID_ROWS));
        for (int b = 0; b < 4; b++) begin
            bank_we[b] = wr_ok && (wcol[0] == b[0]) && (wrow[0] == b[1]);
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        gbni_ram #(
            .WIDTH (gbni_pkg::HEIGHT_W),
            .DEPTH (gbni_pkg::BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr ({wrow[gbni_pkg::ROW_W-1:1], wcol[gbni_pkg::COL_W-1:1]}),
            .i_wdata (r4_h),
            .i_re    (en),
            .i_raddr (raddr[b]),
            .o_rdata (rdata[b])
        );
    end

    // weights and nodata mask
    always_comb begin
        wx1 = {1'b0, r5_dx};
        wy1 = {1'b0, r5_dy};
        wx0 = gbni_pkg::ONE_Q16 - wx1;
        wy0 = gbni_pkg::ONE_Q16 - wy1;
        n_w[0] = gbni_pkg::WGT_W'(wx0 * wy0);
        n_w[1] = gbni_pkg::WGT_W'(wx1 * wy0);
        n_w[2] = gbni_pkg::WGT_W'(wx0 * wy1);
        n_w[3] = gbni_pkg::WGT_W'(wx1 * wy1);
        for (int n = 0; n < 4; n++) begin
            n_hgt[n] = rdata[{r5_py0 ^ n[1], r5_px0 ^ n[0]}];
            n_use[n] = (n_hgt[n] != r_nodata);
        end
    end

    always_comb begin
        n_norm = '0;
        for (int n = 0; n < 4; n++) begin
            if (r6_use[n]) begin
                n_hw[n] = r6_hgt[n] * $signed({1'b0, r6_w[n]});
            end else begin
                n_hw[n] = '0;
            end
            n_norm = n_norm + (r6_use[n] ? r6_w[n] : '0);
        end
    end

    always_comb begin
        mag = r8_acc[gbni_pkg::ACC_W-1] ? -r8_acc : r8_acc;
        n_dividend = gbni_pkg::REM_W'(mag);
        if (r8_acc[gbni_pkg::ACC_W-1]) begin
            n_dividend = n_dividend + gbni_pkg::REM_W'(r8_norm) - gbni_pkg::REM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_inr <= n_inr;
            r5_dx  <= r4_sum[0][gbni_pkg::FRAC_LSB +: gbni_pkg::FRAC_W];
            r5_dy  <= r4_sum[1][gbni_pkg::FRAC_LSB +: gbni_pkg::FRAC_W];
            r5_px0 <= px[0];
            r5_py0 <= py[0];
            r6_inr <= r5_inr;
            r6_hgt <= n_hgt;
            r6_w   <= n_w;
            r6_use <= n_use;
            r7_inr <= r6_inr;
            r7_hw  <= n_hw;
            r7_norm <= n_norm;
            r8_inr <= r7_inr;
            r8_acc <= gbni_pkg::ACC_W'(r7_hw[0]) + gbni_pkg::ACC_W'(r7_hw[1])
                    + gbni_pkg::ACC_W'(r7_hw[2]) + gbni_pkg::ACC_W'(r7_hw[3]);
            r8_norm <= r7_norm;
            r8_nov <= (r7_norm < gbni_pkg::EPS_WGT);
            r_dinr[0] <= r8_inr;
            r_dnov[0] <= r8_nov;
            r_dneg[0] <= r8_acc[gbni_pkg::ACC_W-1];
            r_drem[0] <= n_dividend;
            r_dden[0] <= r8_norm;
            r_dq[0]   <= '0;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        logic [gbni_pkg::REM_W-1:0] trial;
        logic take;
        assign trial = gbni_pkg::REM_W'(r_dden[j]) << (NDIV - 1 - j);
        assign take = (r_drem[j] >= trial);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dinr[j+1] <= r_dinr[j];
                r_dnov[j+1] <= r_dnov[j];
                r_dneg[j+1] <= r_dneg[j];
                r_dden[j+1] <= r_dden[j];
                r_drem[j+1] <= take ? (r_drem[j] - trial) : r_drem[j];
                r_dq[j+1]   <= r_dq[j] | (take ? (gbni_pkg::QUO_W'(1) << (NDIV - 1 - j)) : '0);
            end
        end
    end

    assign qs = r_dneg[NDIV] ? -r_dq[NDIV] : r_dq[NDIV];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oinr <= r_dinr[NDIV];
            r_onov <= r_dinr[NDIV] && r_dnov[NDIV];
            r_oh   <= (r_dinr[NDIV] && !r_dnov[NDIV]) ? $signed(qs) : '0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            for (int j = 0; j <= NDIV; j++) begin
                r_dv[j] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v && (r4_act == gbni_pkg::ACT_QUERY);
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r_dv[0] <= r8_v;
            for (int j = 0; j < NDIV; j++) begin
                r_dv[j+1] <= r_dv[j];
            end
            r_ov <= r_dv[NDIV];
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.height_out = r_oh;
    assign o_out.in_range = r_oinr;
    assign o_out.no_valid_data = r_onov;

endmodule

// File: hdl/gbni_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data and read enable. No dependencies.
`timescale 1ns / 1ps

module gbni_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the bilinear grid interpolator with nodata masking.
// Drives grid writes, queries and register writes, predicts each result and checks it.
// Depends on gbni_pkg, the interfaces in gbni_if and grid_bilinear_nodata_interp.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic               action;
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [31:0] height;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        bit                 drain_first;
    } t_item;

    typedef struct {
        logic signed [31:0] height;
        logic               in_range;
        logic               no_valid_data;
    } t_height_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gbni_in_if  in_ch();
    gbni_out_if out_ch();
    gbni_cfg_if cfg_ch();

    grid_bilinear_nodata_interp u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    t_item              pending_items[$];
    t_height_res        expected_heights[$];
    t_item              cur_item;
    longint             coef [0:6];
    logic signed [31:0] grid_shadow [0:65535];
    bit                 cell_planned [0:65535];
    int                 errors = 0;
    int                 n_queries = 0;
    int                 n_writes = 0;
    int                 n_off_grid = 0;
    int                 n_no_data = 0;
    bit                 quiet = 1'b0;
    int                 send_gap = 0;
    int                 recv_gap = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint to_deg(logic signed [31:0] a);
        longint p;
        p = longint'(a) * 64'sd961263669;
        return p >>> 24;
    endfunction

    function automatic void map_axis(longint off, longint k1, longint d1, longint k2,
                                     longint d2, output longint ip, output longint fr);
        logic signed [127:0] s;
        logic signed [127:0] a;
        logic signed [127:0] b;
        s = off;
        s = s <<< 28;
        a = k1;
        b = d1;
        s = s + a * b;
        a = k2;
        b = d2;
        s = s + a * b;
        a = s >>> gbni_pkg::INT_LSB;
        ip = a[63:0];
        fr = longint'(s[54:39]);
    endfunction

    function automatic void locate(logic signed [31:0] x, logic signed [31:0] y,
                                   output longint px, output longint py,
                                   output longint dx, output longint dy, output bit on_grid);
        longint xd;
        longint yd;
        xd = to_deg(x);
        yd = to_deg(y);
        map_axis(coef[gbni_pkg::CFG_COL_OFFSET], coef[gbni_pkg::CFG_COL_PER_X], xd,
                 coef[gbni_pkg::CFG_COL_PER_Y], yd, px, dx);
        map_axis(coef[gbni_pkg::CFG_ROW_OFFSET], coef[gbni_pkg::CFG_ROW_PER_X], xd,
                 coef[gbni_pkg::CFG_ROW_PER_Y], yd, py, dy);
        on_grid = px >= 0 && px <= gbni_pkg::GRID_COLS - 2
               && py >= 0 && py <= gbni_pkg::GRID_ROWS - 2;
    endfunction

    task automatic predict_height(t_item it);
        t_height_res         r;
        longint              px, py, dx, dy, norm;
        longint              w [0:3];
        longint              hv [0:3];
        logic signed [127:0] acc;
        logic signed [127:0] q;
        bit                  on_grid;
        int                  base;
        if (it.action == gbni_pkg::ACT_WRITE) begin
            grid_shadow[{it.row, it.col}] = it.height;
            return;
        end
        r = '{32'sd0, 1'b0, 1'b0};
        locate(it.qx, it.qy, px, py, dx, dy, on_grid);
        if (on_grid) begin
            r.in_range = 1'b1;
            base = int'(py) * gbni_pkg::GRID_COLS + int'(px);
            hv[0] = grid_shadow[base];
            hv[1] = grid_shadow[base + 1];
            hv[2] = grid_shadow[base + gbni_pkg::GRID_COLS];
            hv[3] = grid_shadow[base + gbni_pkg::GRID_COLS + 1];
            w[0] = (65536 - dx) * (65536 - dy);
            w[1] = dx * (65536 - dy);
            w[2] = (65536 - dx) * dy;
            w[3] = dx * dy;
            acc = 0;
            norm = 0;
            for (int i = 0; i < 4; i++) begin
                if (hv[i] != coef[gbni_pkg::CFG_NODATA]) begin
                    acc = acc + hv[i] * w[i];
                    norm = norm + w[i];
                end
            end
            if (norm < 42950) begin
                r.no_valid_data = 1'b1;
            end else if (acc >= 0) begin
                q = acc / norm;
                r.height = q[31:0];
            end else begin
                q = -((-acc + norm - 1) / norm);
                r.height = q[31:0];
            end
        end
        expected_heights.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.action <= gbni_pkg::ACT_WRITE;
            in_ch.cell_col <= '0;
            in_ch.cell_row <= '0;
            in_ch.cell_height <= '0;
            in_ch.query_x <= '0;
            in_ch.query_y <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                predict_height(cur_item);
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                send_gap <= $urandom_range(0, 7);
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain_first && expected_heights.size() > 0)) begin
                cur_item = pending_items.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.action <= cur_item.action;
                in_ch.cell_col <= cur_item.col;
                in_ch.cell_row <= cur_item.row;
                in_ch.cell_height <= cur_item.height;
                in_ch.query_x <= cur_item.qx;
                in_ch.query_y <= cur_item.qy;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_height_res e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_heights.size() == 0) begin
                    $error("unexpected result transaction");
                    errors++;
                end else begin
                    e = expected_heights.pop_front();
                    n_off_grid += !e.in_range;
                    n_no_data += e.no_valid_data;
                    if (out_ch.height_out !== e.height) begin
                        $error("height_out: expected %0d, got %0d", e.height, out_ch.height_out);
                        errors++;
                    end
                    if (out_ch.in_range !== e.in_range) begin
                        $error("in_range: expected %0b, got %0b", e.in_range, out_ch.in_range);
                        errors++;
                    end
                    if (out_ch.no_valid_data !== e.no_valid_data) begin
                        $error("no_valid_data: expected %0b, got %0b", e.no_valid_data,
                               out_ch.no_valid_data);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 7);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(gbni_pkg::t_cfg_idx idx, logic [gbni_pkg::CFG_W-1:0] v);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == gbni_pkg::CFG_NODATA) begin
            coef[idx] = longint'(signed'(v[31:0]));
        end else begin
            coef[idx] = longint'(signed'(v));
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_ch.valid || expected_heights.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic add_write(logic [7:0] c, logic [7:0] r, logic signed [31:0] h);
        t_item it;
        it = '{gbni_pkg::ACT_WRITE, c, r, h, $urandom, $urandom, 1'b0};
        pending_items.push_back(it);
        cell_planned[{r, c}] = 1'b1;
        n_writes++;
    endtask

    function automatic logic signed [31:0] pick_height();
        if ($urandom_range(0, 3) == 0)
            return coef[gbni_pkg::CFG_NODATA][31:0];
        return $urandom;
    endfunction

    // fill any unwritten neighbour first, and sometimes rewrite written ones
    task automatic add_query(logic signed [31:0] x, logic signed [31:0] y, bit hold);
        t_item  it;
        longint px, py, dx, dy;
        bit     on_grid;
        int     c, r;
        locate(x, y, px, py, dx, dy, on_grid);
        if (on_grid) begin
            for (int i = 0; i < 4; i++) begin
                c = int'(px) + i % 2;
                r = int'(py) + i / 2;
                if (!cell_planned[r * gbni_pkg::GRID_COLS + c] || $urandom_range(0, 5) == 0)
                    add_write(c[7:0], r[7:0], pick_height());
            end
        end
        it = '{gbni_pkg::ACT_QUERY, 8'($urandom), 8'($urandom), $urandom, x, y, hold};
        pending_items.push_back(it);
        n_queries++;
    endtask

    task automatic run_queries(int count, int span);
        int x, y;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                x = $urandom;
                y = $urandom;
            end else begin
                x = int'($urandom_range(0, 2 * span)) - span;
                y = int'($urandom_range(0, 2 * span)) - span;
            end
            if ($urandom_range(0, 5) == 0)
                add_write(8'($urandom), 8'($urandom), pick_height());
            add_query(x, y, i == count / 2);
        end
    endtask

    task automatic set_all(logic [47:0] co, logic [47:0] cx, logic [47:0] cy,
                           logic [47:0] ro, logic [47:0] rx, logic [47:0] ry,
                           logic [47:0] nd);
        wait_idle();
        cfg_write(gbni_pkg::CFG_COL_OFFSET, co);
        cfg_write(gbni_pkg::CFG_COL_PER_X, cx);
        cfg_write(gbni_pkg::CFG_COL_PER_Y, cy);
        cfg_write(gbni_pkg::CFG_ROW_OFFSET, ro);
        cfg_write(gbni_pkg::CFG_ROW_PER_X, rx);
        cfg_write(gbni_pkg::CFG_ROW_PER_Y, ry);
        cfg_write(gbni_pkg::CFG_NODATA, nd);
    endtask

    function automatic logic [47:0] small_coef();
        return 48'(longint'($urandom_range(0, 1 << 29)) - (1 << 28));
    endfunction

    initial begin
        longint one;
        one = 64'sd1 <<< 27;
        for (int i = 0; i < 7; i++) coef[i] = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = gbni_pkg::CFG_COL_OFFSET;
        cfg_ch.data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: every query lands on the top-left cell with no fraction
        add_write(8'd0, 8'd0, 32'sh7fffffff);
        add_write(8'd1, 8'd0, 32'sh80000000);
        add_write(8'd0, 8'd1, 32'sd7);
        add_write(8'd1, 8'd1, 32'sd0);
        add_write(8'd255, 8'd255, 32'sh80000000);
        add_write(8'd255, 8'd0, 32'sh7fffffff);
        add_write(8'd0, 8'd255, -32'sd1);
        add_query(32'sh7fffffff, 32'sh80000000, 1'b0);
        add_query(32'sh80000000, 32'sh7fffffff, 1'b1);
        add_write(8'd0, 8'd0, 32'sd0);
        add_query(32'sd0, 32'sd0, 1'b0);
        add_write(8'd0, 8'd0, -32'sd5);
        add_query(32'sd0, 32'sd0, 1'b0);

        // identity map, nodata at a mid value
        set_all(48'(128 * one), 48'(one), 48'(0), 48'(128 * one), 48'(0), 48'(one),
                48'hffff_0001_8000);
        add_query(32'sh80000000, 32'sd0, 1'b0);
        add_query(32'sd0, 32'sh7fffffff, 1'b0);
        add_query(32'sd0, 32'sd0, 1'b0);
        run_queries(80, 617_000_000);

        set_all(48'(128 * one), 48'(3 * one / 2), 48'(-(one / 4)), 48'(100 * one),
                48'(one / 4), 48'(-(3 * one / 2)), 48'h0000_7fff_ffff);
        run_queries(80, 328_000_000);

        for (int p = 0; p < 3; p++) begin
            set_all(48'($urandom_range(20, 235)) << 27 | 48'($urandom), small_coef(),
                    small_coef(), 48'($urandom_range(20, 235)) << 27 | 48'($urandom),
                    small_coef(), small_coef(), 48'(longint'(signed'($urandom))));
            run_queries(35, 300_000_000);
        end

        set_all(48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff, 48'h8000_0000_0000,
                48'h8000_0000_0000, 48'h8000_0000_0000, 48'h7fff_ffff_ffff,
                48'h0000_8000_0000);
        run_queries(40, 1_000_000);

        set_all(48'({$urandom, $urandom} >> 16), 48'({$urandom, $urandom} >> 16),
                48'({$urandom, $urandom} >> 16), 48'({$urandom, $urandom} >> 16),
                48'({$urandom, $urandom} >> 16), 48'({$urandom, $urandom} >> 16),
                48'({$urandom, $urandom} >> 16));
        run_queries(40, 2_000_000_000);

        set_all(48'(128 * one), 48'(one), 48'(0), 48'(128 * one), 48'(0), 48'(one),
                48'(longint'(signed'($urandom))));
        quiet = 1'b1;
        run_queries(70, 617_000_000);
        wait_idle();

        $display("tb_top: %0d queries (%0d off the grid, %0d without data), %0d cell writes",
                 n_queries, n_off_grid, n_no_data, n_writes);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// File: filelist.f
hdl/gbni_pkg.sv
hdl/gbni_if.sv
hdl/gbni_ram.sv
hdl/grid_bilinear_nodata_interp.sv
tb/tb_top.sv
